/* src/bee_pkg.sv */
// Package for the bootstrap error estimator: constants, command codes, types.
// No dependencies.
`timescale 1ns / 1ps
package bee_pkg;
  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = ADDR_W + 1;
  localparam logic [31:0] LAG_MODULUS = 32'd2147483579;
  localparam logic [31:0] LCG_MUL = 32'd69069;
  localparam logic [31:0] LCG_ADD = 32'd1013904243;
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_RESEED = 2'd3;
  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_SEED_A = 3'd1;
  localparam logic [2:0] REG_SEED_B = 3'd2;
  localparam logic [2:0] REG_SEED_C = 3'd3;
  localparam logic [2:0] REG_LCG = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic        is_signed;
  } div_req_t;
endpackage

/* src/bee_div.sv */
// Iterative 64-bit restoring divider, one quotient bit per cycle.
// Depends on bee_pkg. Signed mode truncates toward zero.
`timescale 1ns / 1ps
module bee_div (
  input  logic              clk,
  input  logic              rst,
  input  bee_pkg::div_req_t req,
  output logic              busy,
  output logic [63:0]       quot
);
  logic [63:0] rem, q, dvs;
  logic [6:0] cnt;
  logic neg;
  logic [64:0] trial;
  logic [63:0] q_step;
  assign trial = {rem[63:0], q[63]} - {1'b0, dvs};
  assign q_step = {q[62:0], ~trial[64]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      dvs <= req.divisor;
      neg <= req.is_signed & req.dividend[63];
      q <= (req.is_signed & req.dividend[63]) ? (~req.dividend + 64'd1) : req.dividend;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
      end else begin
        rem <= {rem[62:0], q[63]};
      end
      // sign fixup folded into the last step so quot is final when busy drops
      q <= (cnt == 7'd1 && neg) ? (~q_step + 64'd1) : q_step;
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
  assign quot = q;
endmodule

/* src/bootstrap_error_estimate.sv */
// Bootstrap standard-error estimator over a 4096-word sample store.
// Load, clear, reseed and empty-store run words complete in the idle state. A run
// sums the n samples, divides for the mean, then for each of R resamples draws n
// indices (one store read per drawn index), sums and divides, and ends with a
// division and the square root; R of 0 skips to the result. One word at a time.
// Sync reset empties the store (count only) and loads the generators from the reset seeds.
`timescale 1ns / 1ps
module bootstrap_error_estimate (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] mean_value,
  output logic [31:0] error_value,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_MDIV = 4'd2, S_MWAIT = 4'd3,
    S_DRAW = 4'd4, S_IMUL = 4'd5, S_RSUM = 4'd6, S_RDIV = 4'd7, S_RWAIT = 4'd8,
    S_SQ = 4'd9, S_ADIV = 4'd10, S_AWAIT = 4'd11, S_SQRT = 4'd12, S_OUT = 4'd13,
    S_ACC = 4'd14;
  localparam int AW = bee_pkg::ADDR_W;
  localparam int CW = bee_pkg::CNT_W;

  logic [3:0] state;
  logic [31:0] store [bee_pkg::MAX_SAMPLES];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_en, rd_vld;
  logic [CW-1:0] count, idx, issued;
  logic [15:0] rcount, rloop;
  logic [30:0] seed_a, seed_b, seed_c;
  logic [31:0] seed_lcg, lag_a, lag_b, lag_c, lcg, xr;
  logic [63:0] sum, mean, prod, accum, sq, rad, root, mag;
  logic sat;
  logic [5:0] sq_cnt;
  bee_pkg::div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;

  bee_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dq));

  assign cfg_ready = 1'b1;
  // a waiting result only holds back a run word; other words pass
  assign in_ready = (state == S_IDLE) &&
                    (!out_valid || out_ready || cmd != bee_pkg::CMD_RUN);

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cmd == bee_pkg::CMD_LOAD && !count[CW-1])
      store[count[AW-1:0]] <= sample_value;
    if (rd_en) rd_data <= store[rd_addr];
  end

  // generator step
  logic [31:0] d0, d1, lcg_n;
  always_comb begin
    d0 = lag_a - lag_c;
    d1 = d0[31] ? d0 + bee_pkg::LAG_MODULUS : d0;
    lcg_n = bee_pkg::LCG_MUL * lcg + bee_pkg::LCG_ADD;
  end

  always_comb begin
    dreq = '0;
    dreq.divisor = {{(64-CW){1'b0}}, count};
    dreq.is_signed = 1'b1;
    dreq.dividend = sum;
    dreq.start = (state == S_MDIV) || (state == S_RDIV) || (state == S_ADIV);
    if (state == S_ADIV) begin
      dreq.dividend = accum;
      dreq.divisor = {48'd0, rcount};
      dreq.is_signed = 1'b0;
    end
    mag = sum[63] ? ~sum + 64'd1 : sum;
  end

  logic [63:0] rtrial;
  assign rtrial = {root[61:0], 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; count <= '0;
      rcount <= 16'd1000; seed_a <= '0; seed_b <= '0; seed_c <= '0; seed_lcg <= '0;
      lag_a <= 32'd1; lag_b <= 32'd1; lag_c <= 32'd1; lcg <= '0; rd_en <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_en <= 1'b0;
      rd_vld <= rd_en;
      if (cfg_valid) begin
        unique case (cfg_index)
          bee_pkg::REG_COUNT:  rcount <= cfg_data[15:0];
          bee_pkg::REG_SEED_A: seed_a <= cfg_data[30:0];
          bee_pkg::REG_SEED_B: seed_b <= cfg_data[30:0];
          bee_pkg::REG_SEED_C: seed_c <= cfg_data[30:0];
          bee_pkg::REG_LCG:    seed_lcg <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          unique case (cmd)
            bee_pkg::CMD_LOAD: if (!count[CW-1]) count <= count + 1'b1;
            bee_pkg::CMD_CLEAR: count <= '0;
            bee_pkg::CMD_RESEED: begin
              lag_a <= {1'b0, seed_a} + 32'd1; lag_b <= {1'b0, seed_b} + 32'd1;
              lag_c <= {1'b0, seed_c} + 32'd1; lcg <= seed_lcg;
            end
            default: begin
              if (count == '0) begin
                mean_value <= '0; error_value <= '0; status <= bee_pkg::ST_EMPTY;
                out_valid <= 1'b1;
              end else begin
                sum <= '0; idx <= '0; issued <= '0; sat <= 1'b0; accum <= '0;
                state <= S_SUM;
              end
            end
          endcase
        end
        S_SUM: begin
          if (issued != count) begin
            rd_en <= 1'b1; rd_addr <= issued[AW-1:0]; issued <= issued + 1'b1;
          end
          if (rd_vld) begin
            sum <= sum + {{32{rd_data[31]}}, rd_data};
            idx <= idx + 1'b1;
            if (idx + 1'b1 == count) state <= S_MDIV;
          end
        end
        S_MDIV: state <= S_MWAIT;
        S_MWAIT: if (!dbusy && dreq.start == 1'b0 && rd_vld == 1'b0) begin
          mean <= dq; rloop <= '0;
          state <= (rcount == 16'd0) ? S_OUT : S_DRAW;
          sum <= '0; idx <= '0; issued <= '0; root <= '0; rad <= '0;
        end
        S_DRAW: begin
          lag_a <= lag_b; lag_b <= lag_c; lag_c <= d1; lcg <= lcg_n;
          xr <= (d1 + lcg_n) ^ 32'h8000_0000;
          state <= S_IMUL;
        end
        S_IMUL: begin
          prod <= {32'd0, xr} * {{(64-CW){1'b0}}, count};
          state <= S_RSUM;
        end
        S_RSUM: begin
          // one read per drawn index: issue only with no read outstanding
          if (issued != count && !rd_en && !rd_vld) begin
            rd_en <= 1'b1; rd_addr <= prod[32+AW-1:32]; issued <= issued + 1'b1;
          end
          if (rd_vld) begin
            sum <= sum + {{32{rd_data[31]}}, rd_data};
            idx <= idx + 1'b1;
            state <= (idx + 1'b1 == count) ? S_RDIV : S_DRAW;
          end
        end
        S_RDIV: state <= S_RWAIT;
        S_RWAIT: if (!dbusy) begin
          sum <= dq - mean; state <= S_SQ;
        end
        S_SQ: begin
          // sum holds the deviation of the resample mean here
          if (mag[63:32] != 32'd0) begin
            sq <= '1; sat <= 1'b1;
          end else begin
            sq <= mag[31:0] * mag[31:0];
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (accum > ~sq) begin accum <= '1; sat <= 1'b1; end
          else accum <= accum + sq;
          sum <= '0; idx <= '0; issued <= '0;
          rloop <= rloop + 16'd1;
          state <= (rloop + 16'd1 == rcount) ? S_ADIV : S_DRAW;
        end
        S_ADIV: state <= S_AWAIT;
        S_AWAIT: if (!dbusy) begin
          rad <= dq; root <= '0; sq_cnt <= 6'd32; state <= S_SQRT;
          accum <= '0;
        end
        S_SQRT: begin
          // digit-by-digit root, two radicand bits per cycle; accum is remainder
          if ({accum[61:0], rad[63:62]} >= rtrial) begin
            accum <= {accum[61:0], rad[63:62]} - rtrial;
            root <= {root[62:0], 1'b1};
          end else begin
            accum <= {accum[61:0], rad[63:62]};
            root <= {root[62:0], 1'b0};
          end
          rad <= {rad[61:0], 2'b00};
          sq_cnt <= sq_cnt - 6'd1;
          if (sq_cnt == 6'd1) state <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          mean_value <= mean[31:0]; error_value <= root[31:0];
          status <= sat ? bee_pkg::ST_SAT : bee_pkg::ST_OK;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(bee_pkg::MAX_SAMPLES)) else $error("count overflow");
endmodule

/* dv/testbench.sv */
// Self-checking testbench for bootstrap_error_estimate: directed and random phases.
// Depends on src/bee_pkg.sv and src/bootstrap_error_estimate.sv.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 120;  // enough for any trailing load/clear/reseed word

  typedef struct {
    logic [31:0] mean;
    logic [31:0] err;
    logic [1:0]  st;
  } estimate_t;

  // Scoreboard: mirrors the store, config and generators; holds expected estimates.
  class estimate_board;
    int signed          store [bee_pkg::MAX_SAMPLES];
    int unsigned        count;
    bit [15:0]          resamples;
    bit [30:0]          seed_a, seed_b, seed_c;
    bit [31:0]          seed_lcg;
    bit [31:0]          lag_a, lag_b, lag_c, lcg;
    estimate_t          pending_q [$];
    int                 errors;
    int                 runs_seen;
    int                 sat_seen;

    function new();
      count = 0;
      resamples = 16'd1000;
      seed_a = 0; seed_b = 0; seed_c = 0; seed_lcg = 0;
      errors = 0; runs_seen = 0; sat_seen = 0;
      reload();
    endfunction

    function void reload();
      lag_a = {1'b0, seed_a} + 32'd1;
      lag_b = {1'b0, seed_b} + 32'd1;
      lag_c = {1'b0, seed_c} + 32'd1;
      lcg = seed_lcg;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        bee_pkg::REG_COUNT:  resamples = data[15:0];
        bee_pkg::REG_SEED_A: seed_a = data[30:0];
        bee_pkg::REG_SEED_B: seed_b = data[30:0];
        bee_pkg::REG_SEED_C: seed_c = data[30:0];
        bee_pkg::REG_LCG:    seed_lcg = data;
        default: ;
      endcase
    endfunction

    // one lagged-subtract + LCG step, scaled to an index below n
    function int unsigned draw(int unsigned n);
      bit [31:0] d, x;
      bit [63:0] prod;
      d = lag_a - lag_c;
      if (d[31]) d = d + bee_pkg::LAG_MODULUS;
      lag_a = lag_b;
      lag_b = lag_c;
      lag_c = d;
      lcg = bee_pkg::LCG_MUL * lcg + bee_pkg::LCG_ADD;
      x = d + lcg;
      prod = {32'd0, x ^ 32'h8000_0000} * {32'd0, n};
      return prod[63:32];
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_word(logic [1:0] c, logic [31:0] v);
      estimate_t e;
      longint signed sum, mean, rs, rmean, dev;
      bit [63:0] mag, sq, acc, root;
      bit sat;
      case (c)
        bee_pkg::CMD_LOAD: begin
          if (count < bee_pkg::MAX_SAMPLES) begin
            store[count] = v;
            count++;
          end
        end
        bee_pkg::CMD_CLEAR: count = 0;
        bee_pkg::CMD_RESEED: reload();
        default: begin
          if (count == 0) begin
            e.mean = 32'd0; e.err = 32'd0; e.st = bee_pkg::ST_EMPTY;
          end else begin
            sum = 0;
            for (int i = 0; i < count; i++) sum += store[i];
            mean = sum / longint'(count);
            acc = 0;
            sat = 0;
            for (int j = 0; j < resamples; j++) begin
              rs = 0;
              for (int i = 0; i < count; i++)
                rs += store[draw(count) % bee_pkg::MAX_SAMPLES];
              rmean = rs / longint'(count);
              dev = rmean - mean;
              mag = (dev < 0) ? -dev : dev;
              if (mag > 64'hFFFF_FFFF) begin
                sq = '1;
                sat = 1;
              end else begin
                sq = mag * mag;
              end
              if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
                acc = '1;
                sat = 1;
              end else begin
                acc = acc + sq;
              end
            end
            root = (resamples != 0) ? int_sqrt(acc / resamples) : 64'd0;
            e.mean = mean[31:0];
            e.err = root[31:0];
            e.st = sat ? bee_pkg::ST_SAT : bee_pkg::ST_OK;
          end
          pending_q.push_back(e);
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH run %0d %s: got %h want %h", runs_seen, what, got, want);
      errors++;
    endtask

    task check(logic [31:0] m, logic [31:0] er, logic [1:0] st);
      estimate_t e;
      if (pending_q.size() == 0) begin
        report("unexpected word", m, 32'd0);
        return;
      end
      e = pending_q.pop_front();
      runs_seen++;
      if (st == bee_pkg::ST_SAT) sat_seen++;
      if (m !== e.mean) report("mean_value", m, e.mean);
      if (er !== e.err) report("error_value", er, e.err);
      if (st !== e.st) report("status", {30'd0, st}, {30'd0, e.st});
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [31:0] sample_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] mean_value;
  logic [31:0] error_value;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  estimate_board board;
  bit  quiet;      // final stretch: no idling on either side
  bit  hold_req;   // ask the receiver for one long hold-off
  int  cycles;
  int  words_sent;

  bootstrap_error_estimate DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .sample_value(sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_value(mean_value), .error_value(error_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run-length watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: checks every accepted estimate, stalls in random bursts,
  // and once holds off for a long stretch so the block backs up.
  initial begin
    int gap;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check(mean_value, error_value, status);
      if (hold_req) begin
        out_ready <= 0;
        gap = 0;
        while (gap < 400) begin
          @(posedge clk);
          gap++;
        end
        hold_req = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Offer one word and hold it until accepted; caller starts at a posedge.
  task automatic send_word(logic [1:0] c, logic [31:0] v);
    in_valid <= 1;
    cmd <= c;
    sample_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_word(c, v);
    words_sent++;
  endtask

  // Random idle burst on the input side between words.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 0;
  endtask

  // Wait until every estimate is back, then let trailing words settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  task automatic random_phase(int items);
    logic [1:0] c;
    int r;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (board.count == 0)
        c = (r < 90) ? bee_pkg::CMD_LOAD : ((r < 95) ? bee_pkg::CMD_RUN : bee_pkg::CMD_RESEED);
      else if (r < 65) c = bee_pkg::CMD_LOAD;
      else if (r < 83) c = bee_pkg::CMD_RUN;
      else if (r < 92) c = bee_pkg::CMD_CLEAR;
      else c = bee_pkg::CMD_RESEED;
      if (c == bee_pkg::CMD_LOAD && board.count >= 14) c = bee_pkg::CMD_CLEAR;
      send_word(c, pick_sample());
      maybe_idle();
    end
  endtask

  task automatic config_random(logic [15:0] rc);
    write_reg(bee_pkg::REG_COUNT, {16'd0, rc});
    write_reg(bee_pkg::REG_SEED_A, $urandom_range(0, 2147483646));
    write_reg(bee_pkg::REG_SEED_B, $urandom_range(0, 2147483646));
    write_reg(bee_pkg::REG_SEED_C, $urandom_range(0, 2147483646));
    write_reg(bee_pkg::REG_LCG, $urandom);
  endtask

  initial begin
    board = new();
    quiet = 0;
    hold_req = 0;
    words_sent = 0;
    rst = 1;
    in_valid = 0;
    cmd = bee_pkg::CMD_LOAD;
    sample_value = 0;
    cfg_valid = 0;
    cfg_index = bee_pkg::REG_COUNT;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty run, extreme samples at the reset count (saturates),
    // zero resample count, reseed, clear, and the seed extremes.
    send_word(bee_pkg::CMD_RUN, 32'h0);
    send_word(bee_pkg::CMD_LOAD, 32'h8000_0000);
    send_word(bee_pkg::CMD_LOAD, 32'h7FFF_FFFF);
    send_word(bee_pkg::CMD_RUN, 32'hFFFF_FFFF);
    drain();
    write_reg(bee_pkg::REG_COUNT, 32'd0);
    write_reg(bee_pkg::REG_SEED_A, 32'd0);
    write_reg(bee_pkg::REG_SEED_B, 32'd2147483646);
    write_reg(bee_pkg::REG_SEED_C, 32'hFFFF_FFFF);  // top bit of the word is dropped
    write_reg(bee_pkg::REG_LCG, 32'h8000_0000);
    send_word(bee_pkg::CMD_RUN, 32'h0);
    send_word(bee_pkg::CMD_RESEED, 32'h0);
    send_word(bee_pkg::CMD_CLEAR, 32'h0);
    send_word(bee_pkg::CMD_RUN, 32'h0);
    drain();
    write_reg(bee_pkg::REG_COUNT, 32'd65535);       // only exercised against an empty store
    send_word(bee_pkg::CMD_RUN, 32'h0);
    drain();
    write_reg(bee_pkg::REG_COUNT, 32'd8);
    write_reg(bee_pkg::REG_SEED_A, 32'd2147483646);
    write_reg(bee_pkg::REG_LCG, 32'hFFFF_FFFF);
    send_word(bee_pkg::CMD_RESEED, 32'h0);
    send_word(bee_pkg::CMD_LOAD, 32'h0);
    send_word(bee_pkg::CMD_RUN, 32'h0);
    send_word(bee_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_word(bee_pkg::CMD_LOAD, 32'h0001_0000);
    send_word(bee_pkg::CMD_LOAD, 32'h5555_AAAA);
    send_word(bee_pkg::CMD_RUN, 32'h0);
    send_word(bee_pkg::CMD_RUN, 32'h0);             // generator carries over between runs
    send_word(bee_pkg::CMD_CLEAR, 32'h0);
    drain();

    // Random phases with varied settings; first one starts with a long output stall.
    config_random(16'd1);
    hold_req = 1;
    random_phase(140);
    drain();
    config_random(16'd16);
    random_phase(140);
    drain();
    config_random(16'd0);
    random_phase(100);
    drain();
    config_random(16'($urandom_range(2, 12)));
    random_phase(160);
    drain();
    quiet = 1;
    config_random(16'($urandom_range(3, 10)));
    random_phase(160);
    drain();

    $display("covered %0d input words and %0d estimates (%0d saturated) in %0d cycles",
             words_sent, board.runs_seen, board.sat_seen, cycles);
    $display("settings swept resample counts 0..65535 and seed extremes; up to 14 samples held");
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* bootstrap_error_estimate.f */
src/bee_pkg.sv
src/bee_div.sv
src/bootstrap_error_estimate.sv
dv/testbench.sv
